// ===== src/rbip_pkg.sv =====
// ----------------------------------------------------------------------------
// rbip_pkg
// Shared types and constants for the reference-counted buffer index pool.
// ----------------------------------------------------------------------------
package rbip_pkg;

    // pool geometry
    localparam int POOL_DEPTH = 256;
    localparam int REF_WIDTH  = 8;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam logic [CNT_W-1:0]     POOL_DEPTH_C = CNT_W'(POOL_DEPTH);
    localparam logic [REF_WIDTH-1:0] REF_MAX      = {REF_WIDTH{1'b1}};

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input kinds
    localparam logic [2:0] KIND_ALLOC = 3'd0;
    localparam logic [2:0] KIND_ADD   = 3'd1;
    localparam logic [2:0] KIND_DROP  = 3'd2;
    localparam logic [2:0] KIND_FREE  = 3'd3;
    localparam logic [2:0] KIND_OWN   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOT_USED = 3'd3;
    localparam logic [2:0] ST_RULE     = 3'd4;

    // input item
    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] buffer_index;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] allocated_index;
        logic             was_freed;
        logic [CNT_W-1:0] free_left;
    } t_out_item;

    // classified operation, as queued for the back end
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_ADD,
        OP_DROP,
        OP_FREE,
        OP_OWN,
        OP_RANGE,
        OP_NOP
    } t_op_code;

    typedef struct packed {
        t_op_code         code;
        logic [IDX_W-1:0] idx;
    } t_op;

    // per-buffer bookkeeping word
    typedef struct packed {
        logic                 in_use;
        logic                 owned;
        logic [REF_WIDTH-1:0] ref_cnt;
    } t_meta;

    // refill request from the configuration register
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] size;
    } t_refill;

endpackage

// ===== src/rbip_fifo.sv =====
// ----------------------------------------------------------------------------
// rbip_fifo
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module rbip_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbip_pkg::t_op i_push_op,
    output logic          o_full,
    input  logic          i_pop,
    output rbip_pkg::t_op o_head_op,
    output logic          o_not_empty
);
    import rbip_pkg::*;

    t_op               r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    // status
    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head_op   = r_entry[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

// ===== src/rbip_front.sv =====
// ----------------------------------------------------------------------------
// rbip_front
// Accepts input items, checks the index range and classifies the operation.
// ----------------------------------------------------------------------------
module rbip_front (
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  rbip_pkg::t_in_item              i_in_item,
    input  logic [rbip_pkg::CNT_W-1:0]      i_pool_size,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output rbip_pkg::t_op                   o_q_op
);
    import rbip_pkg::*;

    logic in_range;

    // handshake: stall only while the queue is full
    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    assign in_range = ({1'b0, i_in_item.buffer_index} < i_pool_size);

    // classify the item
    always_comb begin
        o_q_op.idx = i_in_item.buffer_index;
        unique case (i_in_item.kind)
            KIND_ALLOC: o_q_op.code = OP_ALLOC;
            KIND_ADD:   o_q_op.code = in_range ? OP_ADD  : OP_RANGE;
            KIND_DROP:  o_q_op.code = in_range ? OP_DROP : OP_RANGE;
            KIND_FREE:  o_q_op.code = in_range ? OP_FREE : OP_RANGE;
            KIND_OWN:   o_q_op.code = in_range ? OP_OWN  : OP_RANGE;
            default:    o_q_op.code = OP_NOP;
        endcase
    end

endmodule

// ===== src/rbip_back.sv =====
// ----------------------------------------------------------------------------
// rbip_back
// Executes queued operations against the free stack and buffer metadata.
// ----------------------------------------------------------------------------
module rbip_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbip_pkg::t_refill   i_refill,
    input  logic                i_q_not_empty,
    input  rbip_pkg::t_op       i_q_op,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rbip_pkg::t_out_item o_out_item
);
    import rbip_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // memories
    logic [IDX_W-1:0] m_stack [POOL_DEPTH];
    t_meta            m_meta  [POOL_DEPTH];

    // control and state
    t_state               r_state;
    logic [CNT_W-1:0]     r_free_count;
    logic [CNT_W-1:0]     n_free_count;
    logic [CNT_W-1:0]     r_mark;
    logic [CNT_W-1:0]     n_mark;
    logic [POOL_DEPTH-1:0] r_valid;
    t_op                  r_op;
    logic [IDX_W-1:0]     r_stack_rd;
    t_meta                r_meta_rd;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    // execute-side signals
    logic             out_free;
    logic [CNT_W-1:0] top_pos;
    logic [IDX_W-1:0] top_idx;
    t_meta            cur_meta;
    logic             meta_we;
    logic [IDX_W-1:0] meta_waddr;
    t_meta            meta_wdata;
    logic             stack_we;
    t_out_item        result;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_not_empty && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // stack top, with entries below the low-water mark still at their refill value
    assign top_pos  = r_free_count - CNT_W'(1);
    assign top_idx  = (top_pos < r_mark) ? top_pos[IDX_W-1:0] : r_stack_rd;
    assign cur_meta = r_valid[r_op.idx] ? r_meta_rd : '0;

    // operation execute
    always_comb begin
        n_free_count           = r_free_count;
        n_mark                 = r_mark;
        meta_we                = 1'b0;
        meta_waddr             = r_op.idx;
        meta_wdata             = cur_meta;
        stack_we               = 1'b0;
        result.status          = ST_OK;
        result.allocated_index = '0;
        result.was_freed       = 1'b0;

        unique case (r_op.code)
            OP_ALLOC: begin
                if (r_free_count == '0) begin
                    result.status = ST_EMPTY;
                end else begin
                    n_free_count           = top_pos;
                    result.allocated_index = top_idx;
                    meta_we                = 1'b1;
                    meta_waddr             = top_idx;
                    meta_wdata             = '{in_use: 1'b1, owned: 1'b0, ref_cnt: '0};
                    if (top_pos < r_mark) begin
                        n_mark = top_pos;
                    end
                end
            end
            OP_RANGE: begin
                result.status = ST_RANGE;
            end
            OP_NOP: begin
            end
            default: begin
                if (!cur_meta.in_use) begin
                    result.status = ST_NOT_USED;
                end else begin
                    unique case (r_op.code)
                        OP_ADD: begin
                            if (cur_meta.ref_cnt == REF_MAX) begin
                                result.status = ST_RULE;
                            end else begin
                                meta_we            = 1'b1;
                                meta_wdata.ref_cnt = cur_meta.ref_cnt + REF_WIDTH'(1);
                            end
                        end
                        OP_DROP: begin
                            if (cur_meta.ref_cnt == '0) begin
                                result.status = ST_RULE;
                            end else if (cur_meta.ref_cnt == REF_WIDTH'(1)
                                         && cur_meta.owned) begin
                                meta_we          = 1'b1;
                                meta_wdata       = '0;
                                result.was_freed = 1'b1;
                                if (r_free_count < POOL_DEPTH_C) begin
                                    stack_we     = 1'b1;
                                    n_free_count = r_free_count + CNT_W'(1);
                                end
                            end else begin
                                meta_we            = 1'b1;
                                meta_wdata.ref_cnt = cur_meta.ref_cnt - REF_WIDTH'(1);
                            end
                        end
                        OP_FREE: begin
                            if (cur_meta.ref_cnt != '0 || !cur_meta.owned) begin
                                result.status = ST_RULE;
                            end else begin
                                meta_we          = 1'b1;
                                meta_wdata       = '0;
                                result.was_freed = 1'b1;
                                if (r_free_count < POOL_DEPTH_C) begin
                                    stack_we     = 1'b1;
                                    n_free_count = r_free_count + CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            meta_we          = 1'b1;
                            meta_wdata.owned = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        result.free_left = n_free_count;
    end

    // sequencer, pool counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= POOL_DEPTH_C;
            r_mark       <= POOL_DEPTH_C;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else if (i_refill.en) begin
            r_free_count <= i_refill.size;
            r_mark       <= i_refill.size;
            r_valid      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_q_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_free_count <= n_free_count;
                    r_mark       <= n_mark;
                    if (meta_we) begin
                        r_valid[meta_waddr] <= 1'b1;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op <= i_q_op;
        end
        if (r_state == S_EXEC) begin
            r_out_item <= result;
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_stack_rd <= m_stack[top_pos[IDX_W-1:0]];
        end
        if ((r_state == S_EXEC) && stack_we) begin
            m_stack[r_free_count[IDX_W-1:0]] <= r_op.idx;
        end
    end

    // metadata memory
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_meta_rd <= m_meta[i_q_op.idx];
        end
        if ((r_state == S_EXEC) && meta_we) begin
            m_meta[meta_waddr] <= meta_wdata;
        end
    end

endmodule

// ===== src/refcounted_buffer_index_pool.sv =====
// ----------------------------------------------------------------------------
// refcounted_buffer_index_pool
// Pool of buffer indices with a LIFO free stack and per-buffer ref counts.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one operation item
//     (kind, buffer_index). output channel: o_out_valid / i_out_stall carry
//     one result item per operation (status, allocated_index, was_freed,
//     free_left), in order.
//   config: i_cfg_we with i_cfg_wdata writes pool_size (clamped to 1..256),
//     refills the free stack and clears every in-use, owned bit and count.
//     write it only while no item is in flight.
//   back end: a queued item is popped with its memory reads in S_IDLE,
//     executes in S_EXEC and its result goes to the output register; a
//     new item is taken only after the last one has executed, for the
//     read-modify-write of the metadata and free-stack memories.
//   a four-entry queue lets the input side keep accepting while the back
//     end or the receiver is busy; o_in_stall rises only when it is full.
//   when the receiver stalls, the result holds in the output register and
//     the back end waits before taking the next queued item.
//   reset: pool_size is 256, all 256 buffers are free, no clearing pass is
//     needed; the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
module refcounted_buffer_index_pool (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rbip_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rbip_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [rbip_pkg::CNT_W-1:0]       i_cfg_wdata
);
    import rbip_pkg::*;

    logic [CNT_W-1:0] r_pool_size;
    logic [CNT_W-1:0] cfg_size;
    t_refill          refill;
    logic             q_full;
    logic             q_push;
    t_op              q_push_op;
    logic             q_pop;
    t_op              q_head_op;
    logic             q_not_empty;

    // clamp the written pool size
    always_comb begin
        cfg_size = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_size = CNT_W'(1);
        end else if (i_cfg_wdata > POOL_DEPTH_C) begin
            cfg_size = POOL_DEPTH_C;
        end
    end

    assign refill.en   = i_cfg_we;
    assign refill.size = cfg_size;

    // pool size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_DEPTH_C;
        end else if (i_cfg_we) begin
            r_pool_size <= cfg_size;
        end
    end

    rbip_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_pool_size (r_pool_size),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_op      (q_push_op)
    );

    rbip_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_op   (q_push_op),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_head_op   (q_head_op),
        .o_not_empty (q_not_empty)
    );

    rbip_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_refill      (refill),
        .i_q_not_empty (q_not_empty),
        .i_q_op        (q_head_op),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

// ===== src/rbip_checker.sv =====
// ----------------------------------------------------------------------------
// rbip_checker
// Port-level checks on the buffer index pool, bound to the top level.
// ----------------------------------------------------------------------------
module rbip_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rbip_pkg::t_out_item o_out_item
);
    import rbip_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.free_left <= POOL_DEPTH_C)
        else $error("free count above pool depth");

    // an error result frees nothing and hands out nothing
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK
        |-> !o_out_item.was_freed && o_out_item.allocated_index == '0)
        else $error("error result with side effects");

    // a freeing result never carries an allocated index
    a_free_no_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.was_freed |-> o_out_item.allocated_index == '0)
        else $error("freeing result carries an index");

endmodule

bind refcounted_buffer_index_pool rbip_checker u_rbip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== test/refcounted_buffer_index_pool_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// refcounted_buffer_index_pool_test
// Self-checking bench for the buffer index pool. A directed table covers
// reset contents, LIFO order, every error status and pool size clamping, a
// loop drives one count to saturation, then random phases of mostly valid
// alloc / ref / own / free sequences run, most under random idling on both sides.
// Every result item is checked in order against a shadow model of the pool.
// ----------------------------------------------------------------------------
module refcounted_buffer_index_pool_test;
    import rbip_pkg::*;

    // spare kinds that the block treats as no-ops
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam int NUM_DIR_ROWS     = 28;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 39;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 200000;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic [CNT_W-1:0]    i_cfg_wdata;

    // one row of the directed table: a register write or an operation
    typedef struct {
        logic             is_cfg;
        logic [CNT_W-1:0] cfg_val;
        logic [2:0]       kind;
        logic [IDX_W-1:0] idx;
        logic             typed;
        t_out_item        res;
    } t_stim_row;

    // shadow copy of the pool
    logic [IDX_W-1:0]     sh_stack  [POOL_DEPTH];
    logic                 sh_in_use [POOL_DEPTH];
    logic                 sh_owned  [POOL_DEPTH];
    logic [REF_WIDTH-1:0] sh_refs   [POOL_DEPTH];
    logic [CNT_W-1:0]     sh_free_cnt;
    logic [CNT_W-1:0]     sh_pool_size;

    t_out_item outcome_q [$];
    t_stim_row dir_rows [NUM_DIR_ROWS];

    int  fail_cnt  = 0;
    int  cycle_cnt = 0;
    int  hold_req  = 0;
    bit  no_idle;

    refcounted_buffer_index_pool u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // refill the shadow stack and clear all bookkeeping
    function automatic void pool_refill();
        for (int n = 0; n < POOL_DEPTH; n++) begin
            sh_stack[n]  = IDX_W'(n);
            sh_in_use[n] = 1'b0;
            sh_owned[n]  = 1'b0;
            sh_refs[n]   = '0;
        end
        sh_free_cnt = sh_pool_size;
    endfunction

    // pool_size write, clamped to 1..POOL_DEPTH
    function automatic void pool_size_apply(input logic [CNT_W-1:0] v);
        if (v == '0)
            sh_pool_size = CNT_W'(1);
        else if (v > POOL_DEPTH_C)
            sh_pool_size = POOL_DEPTH_C;
        else
            sh_pool_size = v;
        pool_refill();
    endfunction

    // return a buffer to the free stack
    function automatic void push_free(input logic [IDX_W-1:0] idx);
        if (sh_free_cnt < POOL_DEPTH_C) begin
            sh_stack[sh_free_cnt[IDX_W-1:0]] = idx;
            sh_free_cnt = sh_free_cnt + CNT_W'(1);
        end
        sh_in_use[idx] = 1'b0;
        sh_owned[idx]  = 1'b0;
    endfunction

    // apply one operation to the shadow pool and return its result item
    function automatic t_out_item pool_op_outcome(input logic [2:0] kind,
                                                  input logic [IDX_W-1:0] idx);
        t_out_item        r;
        logic [CNT_W-1:0] top;
        r = '0;
        r.status = ST_OK;
        if (kind == KIND_ALLOC) begin
            if (sh_free_cnt == '0) begin
                r.status = ST_EMPTY;
            end else begin
                top = sh_free_cnt - CNT_W'(1);
                r.allocated_index = sh_stack[top[IDX_W-1:0]];
                sh_free_cnt = top;
                sh_in_use[r.allocated_index] = 1'b1;
            end
        end else if (kind <= KIND_OWN) begin
            if ({1'b0, idx} >= sh_pool_size) begin
                r.status = ST_RANGE;
            end else if (!sh_in_use[idx]) begin
                r.status = ST_NOT_USED;
            end else begin
                case (kind)
                    KIND_ADD: begin
                        if (sh_refs[idx] == REF_MAX)
                            r.status = ST_RULE;
                        else
                            sh_refs[idx] = sh_refs[idx] + REF_WIDTH'(1);
                    end
                    KIND_DROP: begin
                        if (sh_refs[idx] == '0) begin
                            r.status = ST_RULE;
                        end else begin
                            sh_refs[idx] = sh_refs[idx] - REF_WIDTH'(1);
                            if (sh_refs[idx] == '0 && sh_owned[idx]) begin
                                push_free(idx);
                                r.was_freed = 1'b1;
                            end
                        end
                    end
                    KIND_FREE: begin
                        if (sh_refs[idx] != '0 || !sh_owned[idx]) begin
                            r.status = ST_RULE;
                        end else begin
                            push_free(idx);
                            r.was_freed = 1'b1;
                        end
                    end
                    default: begin
                        sh_owned[idx] = 1'b1;
                    end
                endcase
            end
        end
        r.free_left = sh_free_cnt;
        return r;
    endfunction

    // table row builders
    function automatic t_stim_row cfg_row(input logic [CNT_W-1:0] v);
        cfg_row = '{1'b1, v, KIND_ALLOC, '0, 1'b0, '0};
    endfunction

    function automatic t_stim_row op_row(input logic [2:0] k, input logic [IDX_W-1:0] ix);
        op_row = '{1'b0, '0, k, ix, 1'b0, '0};
    endfunction

    function automatic t_stim_row typed_row(input logic [2:0] k, input logic [IDX_W-1:0] ix,
                                            input logic [2:0] st, input logic [IDX_W-1:0] ai,
                                            input logic fr, input logic [CNT_W-1:0] fl);
        t_out_item r;
        r.status          = st;
        r.allocated_index = ai;
        r.was_freed       = fr;
        r.free_left       = fl;
        typed_row = '{1'b0, '0, k, ix, 1'b1, r};
    endfunction

    // offer one item, wait for it to be taken, then log its outcome
    task automatic send_op(input logic [2:0] kind, input logic [IDX_W-1:0] idx,
                           input logic typed, input t_out_item typed_res);
        t_in_item  it;
        t_out_item res;
        it.kind         = kind;
        it.buffer_index = idx;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = pool_op_outcome(kind, idx);
        outcome_q.push_back(typed ? typed_res : res);
    endtask

    // sender gap: stop offering items for a length set by n
    task automatic input_gap(input int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        if (n > 1) repeat (n - 1) @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        input_gap(1);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // pool_size write while the block is idle
    task automatic write_pool_size(input logic [CNT_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        pool_size_apply(v);
    endtask

    // a random in-use buffer, or a random index when none is in use
    function automatic logic [IDX_W-1:0] live_index();
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] ix;
        start = IDX_W'($urandom_range(0, POOL_DEPTH - 1));
        for (int n = 0; n < POOL_DEPTH; n++) begin
            ix = start + IDX_W'(n);
            if (sh_in_use[ix]) return ix;
        end
        return start;
    endfunction

    // one random operation, mostly aimed at buffers in use
    task automatic random_op();
        int unsigned      pick;
        logic [2:0]       k;
        logic [IDX_W-1:0] ix;
        pick = $urandom_range(0, 99);
        if (pick < 26)
            k = KIND_ALLOC;
        else if (pick < 46)
            k = KIND_ADD;
        else if (pick < 64)
            k = KIND_DROP;
        else if (pick < 78)
            k = KIND_OWN;
        else if (pick < 94)
            k = KIND_FREE;
        else
            k = 3'($urandom_range(KIND_SPARE5, KIND_SPARE7));
        if ($urandom_range(0, 99) < 85)
            ix = live_index();
        else
            ix = IDX_W'($urandom_range(0, POOL_DEPTH - 1));
        if (!no_idle && $urandom_range(0, 4) == 0)
            input_gap($urandom_range(1, 4));
        send_op(k, ix, 1'b0, '0);
    endtask

    // compare one field of a result item
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial begin : receiver
        int stall_n;
        int hold_seen;
        hold_seen   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                stall_n   = LONG_HOLD_CYCLES;
                hold_seen = hold_req;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                stall_n = $urandom_range(1, 4);
            end else begin
                stall_n = 0;
            end
            i_out_stall <= (stall_n != 0);
            if (stall_n > 1) repeat (stall_n - 1) @(negedge i_clk);
        end
    end

    // result checking at the rising edge
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $error("result item with nothing outstanding");
                fail_cnt++;
            end else begin
                want = outcome_q.pop_front();
                check_field("status", 32'(want.status), 32'(o_out_item.status));
                check_field("allocated_index", 32'(want.allocated_index),
                            32'(o_out_item.allocated_index));
                check_field("was_freed", 32'(want.was_freed),
                            32'(o_out_item.was_freed));
                check_field("free_left", 32'(want.free_left),
                            32'(o_out_item.free_left));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[refcounted_buffer_index_pool] ERROR");
            $finish;
        end
    end

    // main sequence
    initial begin : stimulus
        logic [CNT_W-1:0] phase_size [NUM_PHASES];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        no_idle     = 1'b0;
        sh_pool_size = POOL_DEPTH_C;
        pool_refill();

        // reset contents, LIFO order, error statuses, size clamping
        dir_rows = '{
            typed_row(KIND_ALLOC, 8'd0,   ST_OK,       8'd255, 1'b0, 9'd255),
            typed_row(KIND_ALLOC, 8'hFF,  ST_OK,       8'd254, 1'b0, 9'd254),
            typed_row(KIND_ADD,   8'd255, ST_OK,       8'd0,   1'b0, 9'd254),
            typed_row(KIND_DROP,  8'd255, ST_OK,       8'd0,   1'b0, 9'd254),
            typed_row(KIND_DROP,  8'd255, ST_RULE,     8'd0,   1'b0, 9'd254),
            typed_row(KIND_FREE,  8'd255, ST_RULE,     8'd0,   1'b0, 9'd254),
            typed_row(KIND_OWN,   8'd255, ST_OK,       8'd0,   1'b0, 9'd254),
            typed_row(KIND_OWN,   8'd255, ST_OK,       8'd0,   1'b0, 9'd254),
            op_row(KIND_ADD, 8'd254),
            typed_row(KIND_FREE,  8'd254, ST_RULE,     8'd0,   1'b0, 9'd254),
            typed_row(KIND_FREE,  8'd255, ST_OK,       8'd0,   1'b1, 9'd255),
            typed_row(KIND_OWN,   8'd255, ST_NOT_USED, 8'd0,   1'b0, 9'd255),
            typed_row(KIND_SPARE5, 8'd0,  ST_OK,       8'd0,   1'b0, 9'd255),
            typed_row(KIND_SPARE6, 8'd255, ST_OK,      8'd0,   1'b0, 9'd255),
            op_row(KIND_SPARE7, 8'hAA),
            op_row(KIND_ALLOC, 8'h55),
            op_row(KIND_OWN, 8'd254),
            op_row(KIND_ADD, 8'd255),
            op_row(KIND_OWN, 8'd255),
            op_row(KIND_DROP, 8'd255),
            op_row(KIND_DROP, 8'd254),
            cfg_row(9'd0),
            typed_row(KIND_ALLOC, 8'd0,   ST_OK,       8'd0,   1'b0, 9'd0),
            typed_row(KIND_ALLOC, 8'd0,   ST_EMPTY,    8'd0,   1'b0, 9'd0),
            typed_row(KIND_ADD,   8'd1,   ST_RANGE,    8'd0,   1'b0, 9'd0),
            typed_row(KIND_DROP,  8'd255, ST_RANGE,    8'd0,   1'b0, 9'd0),
            cfg_row(9'd511),
            typed_row(KIND_ALLOC, 8'd0,   ST_OK,       8'd255, 1'b0, 9'd255)
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                write_pool_size(dir_rows[r].cfg_val);
            else
                send_op(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].typed,
                        dir_rows[r].res);
        end

        // count saturation on buffer 255, then drop to zero while owned
        for (int n = 0; n < 256; n++)
            send_op(KIND_ADD, 8'd255, n == 255, '{ST_RULE, 8'd0, 1'b0, 9'd255});
        send_op(KIND_OWN, 8'd255, 1'b0, '0);
        repeat (255) send_op(KIND_DROP, 8'd255, 1'b0, '0);

        // random phases over several pool sizes
        phase_size = '{9'd256, 9'd2, 9'd5, 9'd1, 9'd300, 9'd0, 9'd9, 9'd256};
        phase_size[6] = CNT_W'($urandom_range(3, 40));
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_pool_size(phase_size[p]);
            if (p == NUM_PHASES - 1)
                no_idle = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // receiver holds off long enough for the input to back up
                if (p == 2 && n == 20)
                    hold_req++;
                // sender waits for everything outstanding
                if (p == 4 && n == 20)
                    drain_results();
                random_op();
            end
        end

        // wind down
        input_gap(1);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && outcome_q.size() == 0)
            $display("[refcounted_buffer_index_pool] OK");
        else
            $display("[refcounted_buffer_index_pool] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/rbip_pkg.sv
src/rbip_fifo.sv
src/rbip_front.sv
src/rbip_back.sv
src/refcounted_buffer_index_pool.sv
src/rbip_checker.sv
test/refcounted_buffer_index_pool_test.sv
